>>> hw/rtl/pisd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pisd_pkg
// Shared types and constants for the packed integer stream decoder.
// ---------------------------------------------------------------------------
package pisd_pkg;

  // Command codes carried with the first byte of a value
  localparam logic CMD_COMPACT = 1'b0;
  localparam logic CMD_GROUPS  = 1'b1;

  // Escape bytes of the signed compact format
  localparam logic [7:0] ESC_SHORT = 8'h80;
  localparam logic [7:0] ESC_LONG  = 8'h81;

  // Decoder state: kind of value in progress
  typedef enum logic [1:0] {
    KIND_IDLE  = 2'd0,
    KIND_SHORT = 2'd1,
    KIND_LONG  = 2'd2,
    KIND_GROUP = 2'd3
  } kind_t;

  // Input word: one byte of the stream plus its command
  typedef struct packed {
    logic [7:0] in_byte;
    logic       command;
  } in_word_t;

  // Result word: one decoded integer
  typedef struct packed {
    logic signed [31:0] value;
    logic               value_format;
  } out_word_t;

endpackage

>>> hw/rtl/pisd_in_reg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pisd_in_reg
// Input register: captures one word and holds it until the decoder takes it.
// ---------------------------------------------------------------------------
module pisd_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pisd_pkg::in_word_t in_data,
  input  logic               take,
  output logic               hold_valid,
  output pisd_pkg::in_word_t hold_data
);

  logic               valid_r;
  logic               valid_nxt;
  pisd_pkg::in_word_t data_r;
  logic               accept;

  // Stall while a held word cannot move on this cycle
  assign in_stall = valid_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the payload on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_data;
    end
  end

  assign hold_valid = valid_r;
  assign hold_data  = data_r;

endmodule

>>> hw/rtl/pisd_decode.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pisd_decode
// Value assembly: tracks format, byte count and partial bits, and forms a
// result on the byte that completes a value.
// ---------------------------------------------------------------------------
module pisd_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  pisd_pkg::in_word_t  word,
  output logic                res_valid,
  output pisd_pkg::out_word_t res_data
);

  pisd_pkg::kind_t kind_r;
  pisd_pkg::kind_t kind_nxt;
  logic [1:0]      cnt_r;
  logic [1:0]      cnt_nxt;
  logic [23:0]     part_r;
  logic [23:0]     part_nxt;
  logic [7:0]      b;

  assign b = word.in_byte;

  // Next state
  always_comb begin
    kind_nxt = kind_r;
    unique case (kind_r)
      pisd_pkg::KIND_IDLE: begin
        if (word.command == pisd_pkg::CMD_COMPACT) begin
          if (b == pisd_pkg::ESC_SHORT) begin
            kind_nxt = pisd_pkg::KIND_SHORT;
          end else if (b == pisd_pkg::ESC_LONG) begin
            kind_nxt = pisd_pkg::KIND_LONG;
          end
        end else if (b[7]) begin
          kind_nxt = pisd_pkg::KIND_GROUP;
        end
      end
      pisd_pkg::KIND_SHORT: begin
        if (cnt_r == 2'd1) kind_nxt = pisd_pkg::KIND_IDLE;
      end
      pisd_pkg::KIND_LONG: begin
        if (cnt_r == 2'd3) kind_nxt = pisd_pkg::KIND_IDLE;
      end
      pisd_pkg::KIND_GROUP: begin
        // a clear continuation bit or the fourth byte ends the value
        if (!b[7] || cnt_r == 2'd3) kind_nxt = pisd_pkg::KIND_IDLE;
      end
      default: kind_nxt = pisd_pkg::KIND_IDLE;
    endcase
  end

  // Datapath and result
  always_comb begin
    cnt_nxt                = cnt_r + 2'd1;
    part_nxt               = part_r;
    res_valid              = 1'b0;
    res_data.value         = 32'sd0;
    res_data.value_format  = pisd_pkg::CMD_COMPACT;
    unique case (kind_r)
      pisd_pkg::KIND_IDLE: begin
        cnt_nxt  = 2'd0;
        part_nxt = 24'd0;
        if (word.command == pisd_pkg::CMD_COMPACT) begin
          if (b != pisd_pkg::ESC_SHORT && b != pisd_pkg::ESC_LONG) begin
            res_valid      = 1'b1;
            res_data.value = {{24{b[7]}}, b};
          end
        end else if (b[7]) begin
          cnt_nxt  = 2'd1;
          part_nxt = {16'd0, b};
        end else begin
          res_valid             = 1'b1;
          res_data.value        = {24'd0, b};
          res_data.value_format = pisd_pkg::CMD_GROUPS;
        end
      end
      pisd_pkg::KIND_SHORT: begin
        if (cnt_r == 2'd0) begin
          part_nxt[7:0] = b;
        end else begin
          res_valid      = 1'b1;
          res_data.value = {{16{b[7]}}, b, part_r[7:0]};
        end
      end
      pisd_pkg::KIND_LONG: begin
        case (cnt_r)
          2'd0:    part_nxt[7:0]   = b;
          2'd1:    part_nxt[15:8]  = b;
          2'd2:    part_nxt[23:16] = b;
          default: begin
            res_valid      = 1'b1;
            res_data.value = {b, part_r};
          end
        endcase
      end
      pisd_pkg::KIND_GROUP: begin
        res_data.value_format = pisd_pkg::CMD_GROUPS;
        case (cnt_r)
          2'd1: begin
            part_nxt       = {9'd0, b, part_r[6:0]};
            res_valid      = !b[7];
            res_data.value = {17'd0, b, part_r[6:0]};
          end
          2'd2: begin
            part_nxt       = {2'd0, b, part_r[13:0]};
            res_valid      = !b[7];
            res_data.value = {10'd0, b, part_r[13:0]};
          end
          default: begin
            // fourth byte: sign-extend from bit 28
            res_valid      = 1'b1;
            res_data.value = {{3{b[7]}}, b, part_r[20:0]};
          end
        endcase
      end
      default: begin
        cnt_nxt = 2'd0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= pisd_pkg::KIND_IDLE;
      cnt_r  <= 2'd0;
      part_r <= 24'd0;
    end else if (advance) begin
      kind_r <= kind_nxt;
      cnt_r  <= cnt_nxt;
      part_r <= part_nxt;
    end
  end

endmodule

>>> hw/rtl/pisd_out_reg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pisd_out_reg
// Result register: holds a finished word until the receiver takes it.
// ---------------------------------------------------------------------------
module pisd_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  pisd_pkg::out_word_t res_data,
  output logic                space,
  output logic                out_valid,
  input  logic                out_stall,
  output pisd_pkg::out_word_t out_data
);

  logic                valid_r;
  logic                valid_nxt;
  pisd_pkg::out_word_t data_r;

  // Room for a new word when empty or being drained this cycle
  assign space = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load the payload with each new result
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

>>> hw/rtl/packed_integer_stream_decoder_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// packed_integer_stream_decoder_unit
// Rebuilds 32-bit integers from a packed byte stream in two formats.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_data carries one stream byte per
//   word together with a command bit that picks the format of a value that
//   starts on that byte (compact signed or 7-bit groups).
//   Output channel out_valid / out_stall / out_data carries one decoded
//   integer per word, emitted on the byte that completes a value.
//   A completing byte's integer reaches out_data via the input register,
//   then decode into the result register. Throughput: one byte per cycle
//   sustained while out_stall is low; the decode is a single pass of shifts
//   and muxes between the input register and the result register.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   decoder to idle between values.
//   While out_stall is high with a result held, the decoder freezes; the
//   input register still takes a byte if it is empty, then in_stall rises.
// ---------------------------------------------------------------------------
module packed_integer_stream_decoder_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pisd_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pisd_pkg::out_word_t out_data
);

  logic                hold_valid;
  pisd_pkg::in_word_t  hold_data;
  logic                space;
  logic                advance;
  logic                res_valid;
  pisd_pkg::out_word_t res_data;

  // Move the held byte through the decoder when the result side has room
  assign advance = hold_valid && space;

  pisd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .take       (advance),
    .hold_valid (hold_valid),
    .hold_data  (hold_data)
  );

  pisd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .word      (hold_data),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  pisd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .res_data  (res_data),
    .space     (space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
